// ----- rtl/masked_pixel_to_bgr24_converter_assert.svh -----
// assertion macros of the converter, used by the back part
`ifndef MASKED_PIXEL_TO_BGR24_CONVERTER_ASSERT_SVH
`define MASKED_PIXEL_TO_BGR24_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MPBGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MPBGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mpbgr_pkg.sv -----
// types, constants and helper functions of the pixel to bgr24 converter
package mpbgr_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;
  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_STEPS = 8;

  // configuration register indexes
  localparam logic [2:0] REG_PIXEL_BITS  = 3'd0;
  localparam logic [2:0] REG_PALETTED    = 3'd1;
  localparam logic [2:0] REG_RED_MASK    = 3'd2;
  localparam logic [2:0] REG_GREEN_MASK  = 3'd3;
  localparam logic [2:0] REG_BLUE_MASK   = 3'd4;

  // item kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  typedef struct packed {
    logic [5:0]                        pixel_bits;
    logic                              paletted;
    logic [NUM_CHANNELS-1:0][5:0]      shift;
    logic [NUM_CHANNELS-1:0][7:0]      fmask;
  } cfg_t;

  // one classified pixel between front and back
  typedef struct packed {
    logic                              is_pal;
    logic                              eol;
    logic [NUM_CHANNELS-1:0][15:0]     num;
    logic [NUM_CHANNELS-1:0][7:0]      div;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

  // trailing zero count, 32 for an empty mask
  function automatic logic [5:0] trailing_zeros(input logic [31:0] mask);
    logic [31:0] x;
    logic [5:0]  n;
    x = mask;
    n = 6'd0;
    if (mask == 32'd0) begin
      n = 6'd32;
    end else begin
      if (x[15:0] == 16'd0) begin
        n = n + 6'd16;
        x = x >> 16;
      end
      if (x[7:0] == 8'd0) begin
        n = n + 6'd8;
        x = x >> 8;
      end
      if (x[3:0] == 4'd0) begin
        n = n + 6'd4;
        x = x >> 4;
      end
      if (x[1:0] == 2'd0) begin
        n = n + 6'd2;
        x = x >> 2;
      end
      if (x[0] == 1'b0) begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // shifted mask capped at 255
  function automatic logic [7:0] field_mask(input logic [31:0] mask);
    logic [31:0] m;
    m = mask >> trailing_zeros(mask);
    return (m > 32'd255) ? 8'hFF : m[7:0];
  endfunction

endpackage

// ----- rtl/mpbgr_front.sv -----
// front part: accepts items, owns the palette store, builds divide jobs
module mpbgr_front #(
  parameter int unsigned PALETTE_ENTRIES = mpbgr_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  mpbgr_pkg::cfg_t     cfg,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic                kind,
  input  logic [31:0]         pixel_word,
  input  logic                end_of_line,
  input  logic [7:0]          palette_index,
  input  logic [7:0]          palette_red,
  input  logic [7:0]          palette_green,
  input  logic [7:0]          palette_blue,
  output logic                push_valid,
  input  logic                push_ready,
  output mpbgr_pkg::entry_t   push_entry
);
  import mpbgr_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

  logic                               accept;
  logic                               st_free;
  logic                               pal_ok;
  logic                               produce;
  logic                               idx_in_range;
  logic                               rd_in_range;
  logic [PALETTE_ENTRIES-1:0]         pal_valid;
  logic [23:0]                        pal_mem [PALETTE_ENTRIES];
  logic [23:0]                        rd_data;
  logic                               rd_hit;
  logic                               st_valid;
  logic                               st_is_pal;
  logic                               st_eol;
  logic [NUM_CHANNELS-1:0][15:0]      st_num;
  logic [NUM_CHANNELS-1:0][7:0]       st_div;
  logic [31:0]                        word_kept;
  logic [NUM_CHANNELS-1:0][7:0]       field;

  assign pal_ok       = cfg.paletted && (cfg.pixel_bits == 6'd8);
  assign idx_in_range = {1'b0, palette_index} < 9'(PALETTE_ENTRIES);
  assign rd_in_range  = {1'b0, pixel_word[7:0]} < 9'(PALETTE_ENTRIES);
  assign produce      = (kind == KIND_PIXEL) && (cfg.pixel_bits >= 6'd8) &&
                        (!cfg.paletted || (cfg.pixel_bits == 6'd8));

  assign st_free     = !st_valid || push_ready;
  assign pixel_stall = !st_free;
  assign accept      = pixel_valid && st_free;
  assign push_valid  = st_valid;

  // keep whole bytes of the pixel width
  assign word_kept = (cfg.pixel_bits <= 6'd8)  ? (pixel_word & 32'h0000_00FF) :
                     (cfg.pixel_bits <= 6'd16) ? (pixel_word & 32'h0000_FFFF) :
                     (cfg.pixel_bits <= 6'd24) ? (pixel_word & 32'h00FF_FFFF) :
                                                 pixel_word;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      field[c] = 8'(word_kept >> cfg.shift[c]) & cfg.fmask[c];
    end
  end

  // palette store
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_PALETTE) && pal_ok && idx_in_range) begin
      pal_mem[palette_index[IDX_W-1:0]] <= {palette_red, palette_green, palette_blue};
    end
    if (accept && (kind == KIND_PIXEL)) begin
      rd_data <= pal_mem[pixel_word[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (accept && (kind == KIND_PALETTE) && pal_ok && idx_in_range) begin
      pal_valid[palette_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= produce;
    end else if (push_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hit    <= rd_in_range && pal_valid[pixel_word[IDX_W-1:0]];
      st_is_pal <= cfg.paletted;
      st_eol    <= end_of_line;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        st_num[c] <= {field[c], 8'h00} - {8'h00, field[c]};
        st_div[c] <= cfg.fmask[c];
      end
    end
  end

  // palette bytes ride in the low byte of the numerator
  always_comb begin
    push_entry.is_pal = st_is_pal;
    push_entry.eol    = st_eol;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      push_entry.div[c] = st_div[c];
      if (st_is_pal) begin
        push_entry.num[c] = {8'h00, rd_hit ? rd_data[8*c +: 8] : 8'h00};
      end else begin
        push_entry.num[c] = st_num[c];
      end
    end
  end

endmodule

// ----- rtl/mpbgr_queue.sv -----
// short queue of divide jobs between front and back
module mpbgr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mpbgr_pkg::entry_t  push_entry,
  output logic               pop_valid,
  input  logic               pop,
  output mpbgr_pkg::entry_t  pop_entry
);
  import mpbgr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mpbgr_back.sv -----
// back part: per-channel radix-2 dividers and the result register
`include "masked_pixel_to_bgr24_converter_assert.svh"

module mpbgr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop,
  input  mpbgr_pkg::entry_t  pop_entry,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  output logic               line_end_out
);
  import mpbgr_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  back_state_t                        state;
  back_state_t                        state_next;
  logic [STEP_W-1:0]                  step;
  logic                               out_free;
  logic                               load_out;
  logic                               eol;
  logic [NUM_CHANNELS-1:0][7:0]       rem;
  logic [NUM_CHANNELS-1:0][7:0]       quo;
  logic [NUM_CHANNELS-1:0][7:0]       lo;
  logic [NUM_CHANNELS-1:0][7:0]       div;
  logic [NUM_CHANNELS-1:0]            dz;
  logic [NUM_CHANNELS-1:0][8:0]       rem2;
  logic [NUM_CHANNELS-1:0]            ge;
  logic [NUM_CHANNELS-1:0][7:0]       rem_sub;
  logic [NUM_CHANNELS-1:0][7:0]       res;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          state_next = pop_entry.is_pal ? BK_DONE : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step == '0) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE:   pop = pop_valid;
      BK_DIVIDE: pop = 1'b0;
      BK_DONE:   load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // one restoring step per lane
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      rem2[c]    = {rem[c], lo[c][7]};
      ge[c]      = rem2[c] >= {1'b0, div[c]};
      rem_sub[c] = 8'(rem2[c] - {1'b0, div[c]});
      res[c]     = dz[c] ? 8'h00 : quo[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      eol  <= pop_entry.eol;
      step <= STEP_W'(DIV_STEPS - 1);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        div[c] <= pop_entry.div[c];
        if (pop_entry.is_pal) begin
          quo[c] <= pop_entry.num[c][7:0];
          dz[c]  <= 1'b0;
        end else begin
          quo[c] <= 8'h00;
          dz[c]  <= pop_entry.div[c] == 8'h00;
        end
        rem[c] <= pop_entry.num[c][15:8];
        lo[c]  <= pop_entry.num[c][7:0];
      end
    end else if (state == BK_DIVIDE) begin
      step <= step - 1'b1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rem[c] <= ge[c] ? rem_sub[c] : rem2[c][7:0];
        quo[c] <= {quo[c][6:0], ge[c]};
        lo[c]  <= {lo[c][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blue     <= res[CH_BLUE];
      out_green    <= res[CH_GREEN];
      out_red      <= res[CH_RED];
      line_end_out <= eol;
    end
  end

  `MPBGR_ASSERT_NOW(a_pop_only_idle, pop, state == BK_IDLE, "job taken outside idle")
  `MPBGR_ASSERT_NOW(a_rem_below_div, (state == BK_DIVIDE) && !dz[CH_RED], rem[CH_RED] < div[CH_RED], "red remainder reached divisor")
  `MPBGR_ASSERT_NEXT(a_done_loads, (state == BK_DONE) && out_free, result_valid, "finished pixel not presented")

endmodule

// ----- rtl/masked_pixel_to_bgr24_converter.sv -----
// top level of the masked pixel to bgr24 converter
//
// usage: pixel and palette beats enter on pixel_valid/pixel_stall, one bgr24
// result beat per valid pixel leaves on result_valid/result_stall. palette
// beats and pixels of an invalid format give no result.
// configuration is a plain write port (cfg_write, cfg_index, cfg_data); the
// user must write it only while the converter is idle, which the block does
// not enforce; masks are reduced to a shift and a capped field mask at the write.
// a masked pixel passes the front's stage register, the job queue, the back
// part's idle, divide and done states and the result register; a paletted
// pixel skips the divide state. the back part's three 8-step radix-2 dividers
// (idle, 8 divide steps, result hand-off) take one job at a time, the next
// only after the last is handed off. the front takes a new beat every cycle
// while the two-entry job queue has room, so palette writes stream at full rate.
// reset clears the configuration, the queue and the palette valid bits at
// once: every palette entry reads as zero until written, no clearing pass.
// a stalled receiver holds the result register; the back part waits, then
// the queue fills, then pixel_stall rises.
module masked_pixel_to_bgr24_converter #(
  parameter int unsigned PALETTE_ENTRIES = mpbgr_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input channel
  input  logic         pixel_valid,
  output logic         pixel_stall,
  input  logic         kind,
  input  logic [31:0]  pixel_word,
  input  logic         end_of_line,
  input  logic [7:0]   palette_index,
  input  logic [7:0]   palette_red,
  input  logic [7:0]   palette_green,
  input  logic [7:0]   palette_blue,
  // result channel
  output logic         result_valid,
  input  logic         result_stall,
  output logic [7:0]   out_blue,
  output logic [7:0]   out_green,
  output logic [7:0]   out_red,
  output logic         line_end_out
);
  import mpbgr_pkg::*;

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  entry_t  push_entry;
  logic    pop_valid;
  logic    pop;
  entry_t  pop_entry;

  // configuration registers, masks kept as shift plus field mask
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_bits <= 6'd0;
      cfg.paletted   <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cfg.shift[c] <= 6'd32;
        cfg.fmask[c] <= 8'h00;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIXEL_BITS: cfg.pixel_bits <= cfg_data[5:0];
        REG_PALETTED:   cfg.paletted   <= cfg_data[0];
        REG_RED_MASK: begin
          cfg.shift[CH_RED] <= trailing_zeros(cfg_data);
          cfg.fmask[CH_RED] <= field_mask(cfg_data);
        end
        REG_GREEN_MASK: begin
          cfg.shift[CH_GREEN] <= trailing_zeros(cfg_data);
          cfg.fmask[CH_GREEN] <= field_mask(cfg_data);
        end
        REG_BLUE_MASK: begin
          cfg.shift[CH_BLUE] <= trailing_zeros(cfg_data);
          cfg.fmask[CH_BLUE] <= field_mask(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // front: accept, palette store, field extraction
  mpbgr_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .kind          (kind),
    .pixel_word    (pixel_word),
    .end_of_line   (end_of_line),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // job queue decouples the two sides
  mpbgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  // back: scaling dividers and result register
  mpbgr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .line_end_out (line_end_out)
  );

endmodule
